// ----- sv/tdec_pkg.sv -----
// Shared types, codes and character decode functions for the text decoder.
package tdec_pkg;

  typedef enum logic [1:0] {
    MODE_BASE64 = 2'd0,
    MODE_ROT13  = 2'd1,
    MODE_HEX    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  localparam int unsigned MaxBytes = 3;

  // Result bundle for one input request: up to three bytes, sent in order.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;  // bytes[0] goes out first
    logic [1:0]               num;    // entries to send, 1..3
    logic                     has_data;
    logic                     last;
  } bundle_t;

  // {invalid, value}: invalid set for characters outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    priority if (c >= 8'h41 && c <= 8'h5a) begin
      t = c - 8'h41;
      sextet_of = {1'b0, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      t = c - 8'h61 + 8'd26;
      sextet_of = {1'b0, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      sextet_of = {1'b0, t[5:0]};
    end else if (c == 8'h2b) begin
      sextet_of = {1'b0, 6'd62};
    end else if (c == 8'h2f) begin
      sextet_of = {1'b0, 6'd63};
    end else begin
      sextet_of = {1'b1, 6'd0};
    end
  endfunction

  // Non-hex characters count as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    priority if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h61 + 8'd10;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h41 + 8'd10;
    end else begin
      t = 8'd0;
    end
    hex_value = t[3:0];
  endfunction

  function automatic logic [7:0] rot13(input logic [7:0] c);
    logic [7:0] off;
    off = 8'd0;
    rot13 = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      off = c - 8'h61;
      rot13 = (off < 8'd13) ? c + 8'd13 : c - 8'd13;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      off = c - 8'h41;
      rot13 = (off < 8'd13) ? c + 8'd13 : c - 8'd13;
    end
  endfunction

endpackage

// ----- sv/tdec_in_if.sv -----
// Input character channel: valid/ready with one character and end-of-block mark.
interface tdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// ----- sv/tdec_out_if.sv -----
// Output byte channel: valid/ready with one decoded byte and its flags.
interface tdec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last_out;

  modport source (output valid, output out_byte, output has_byte, output last_out,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input last_out,
                  output ready);
endinterface

// ----- sv/tdec_cfg_if.sv -----
// Configuration write channel: valid/ready with the decode mode.
interface tdec_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] decode_mode;

  modport source (output valid, output decode_mode, input ready);
  modport sink   (input valid, input decode_mode, output ready);
endinterface

// ----- sv/tdec_core.sv -----
// Input register, mode register, decoder state and per-request decode logic.
module tdec_core
  import tdec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_mode_i,
  output logic       bund_valid_o,
  input  logic       bund_ready_i,
  output bundle_t    bund_o
);

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  mode_e       mode_q;

  logic [17:0] group_q, group_d;
  logic [1:0]  fill_q, fill_d;
  logic        stopped_q, stopped_d;
  logic [3:0]  hi_q, hi_d;
  logic        pend_q, pend_d;

  logic [1:0]  num;
  logic        consume;
  logic [6:0]  sx;
  logic [3:0]  dig;
  logic [23:0] w;

  always_comb begin
    group_d   = group_q;
    fill_d    = fill_q;
    stopped_d = stopped_q;
    hi_d      = hi_q;
    pend_d    = pend_q;
    num       = 2'd0;
    w         = 24'd0;
    sx        = sextet_of(s1_byte_q);
    dig       = hex_value(s1_byte_q);
    bund_o    = '0;

    unique case (mode_q)
      MODE_BASE64: begin
        if (!stopped_q) begin
          if (sx[6]) begin
            stopped_d = 1'b1;
          end else if (fill_q == 2'd3) begin
            w = {group_q, sx[5:0]};
            bund_o.bytes[0] = w[23:16];
            bund_o.bytes[1] = w[15:8];
            bund_o.bytes[2] = w[7:0];
            num     = 2'd3;
            group_d = 18'd0;
            fill_d  = 2'd0;
          end else begin
            group_d = {group_q[11:0], sx[5:0]};
            fill_d  = fill_q + 2'd1;
          end
        end
        // end of block: a group of n sextets flushes n-1 bytes
        if (s1_last_q && fill_d > 2'd1) begin
          w = (fill_d == 2'd3) ? {group_d, 6'd0} : {group_d[11:0], 12'd0};
          bund_o.bytes[0] = w[23:16];
          bund_o.bytes[1] = w[15:8];
          num = fill_d - 2'd1;
        end
      end
      MODE_ROT13: begin
        bund_o.bytes[0] = rot13(s1_byte_q);
        num = 2'd1;
      end
      MODE_HEX: begin
        if (pend_q) begin
          bund_o.bytes[0] = {hi_q, dig};
          num    = 2'd1;
          pend_d = 1'b0;
          hi_d   = 4'd0;
        end else if (s1_last_q) begin
          bund_o.bytes[0] = {4'd0, dig};
          num = 2'd1;
        end else begin
          hi_d   = dig;
          pend_d = 1'b1;
        end
      end
      MODE_NONE: begin
      end
      default: begin
      end
    endcase

    bund_o.has_data = (num != 2'd0);
    bund_o.num      = (num == 2'd0) ? 2'd1 : num;  // empty end marker is one entry
    bund_o.last     = s1_last_q;

    if (s1_last_q) begin
      group_d   = 18'd0;
      fill_d    = 2'd0;
      stopped_d = 1'b0;
      hi_d      = 4'd0;
      pend_d    = 1'b0;
    end
  end

  assign bund_valid_o = s1_valid_q && (num != 2'd0 || s1_last_q);
  assign consume      = s1_valid_q && (!bund_valid_o || bund_ready_i);
  assign in_ready_o   = !s1_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      mode_q     <= MODE_BASE64;
      group_q    <= 18'd0;
      fill_q     <= 2'd0;
      stopped_q  <= 1'b0;
      hi_q       <= 4'd0;
      pend_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_mode_i);
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (consume) begin
        group_q   <= group_d;
        fill_q    <= fill_d;
        stopped_q <= stopped_d;
        hi_q      <= hi_d;
        pend_q    <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= in_last_i;
    end
  end

endmodule

// ----- sv/tdec_serial.sv -----
// Result register that sends a bundle of up to three bytes one per cycle while the output is ready.
module tdec_serial
  import tdec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       bund_valid_i,
  output logic       bund_ready_o,
  input  bundle_t    bund_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       last_out_o
);

  bundle_t    bund_q;
  logic [1:0] cnt_q;
  logic [1:0] idx_q;
  logic       out_take;

  assign out_valid_o  = (cnt_q != 2'd0);
  assign out_take     = out_valid_o && out_ready_i;
  assign bund_ready_o = (cnt_q == 2'd0) || (out_take && cnt_q == 2'd1);

  always_comb begin
    unique case (idx_q)
      2'd0:    out_byte_o = bund_q.bytes[0];
      2'd1:    out_byte_o = bund_q.bytes[1];
      2'd2:    out_byte_o = bund_q.bytes[2];
      default: out_byte_o = 8'd0;
    endcase
  end

  assign has_byte_o = bund_q.has_data;
  assign last_out_o = bund_q.last && (cnt_q == 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (bund_valid_i && bund_ready_o) begin
      cnt_q <= bund_i.num;
      idx_q <= 2'd0;
    end else if (out_take) begin
      cnt_q <= cnt_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bund_valid_i && bund_ready_o) begin
      bund_q <= bund_i;
    end
  end

endmodule

// ----- sv/text_decoder_base64_rot13_hex.sv -----
// Top level of the streaming base64 / rot13 / hex text decoder.
//
// One character request enters per cycle on in_req_i while in_req_i.ready is
// high; each is registered, decoded combinationally against the mode register
// and the group state, and its results (up to three bytes) land in a result
// register that hands them out one per cycle on out_res_o while out_res_o.ready
// is high. A new character is taken every cycle as long as the previous
// character's results fit: rot13 and hex sustain one character per cycle, and
// a base64 character that completes a group of four gives three bytes, and while
// they drain, the next character that produces bytes waits. The output register
// is the only limit. A request passes through the input and result registers.
// Modes: 0 base64 (alphabet A-Z a-z 0-9 + /, stops at '=' or any other
// character for the rest of the block, a partial group of n characters flushes
// n-1 bytes at the end), 1 rot13, 2 hex pairs (lone trailing digit gives its own
// value, non-hex counts as zero), 3 no data. A block end always produces a
// final result with last_out set; if the last character made no byte, that is
// an empty marker with has_byte low. Mode writes are accepted at any time
// (cfg_i.ready is tied high) and are meant to happen while the block is idle.
module text_decoder_base64_rot13_hex
  import tdec_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tdec_in_if.sink   in_req_i,
  tdec_out_if.source out_res_o,
  tdec_cfg_if.sink  cfg_i
);

  bundle_t bund;
  logic    bund_valid;
  logic    bund_ready;

  // mode register is always writable
  assign cfg_i.ready = 1'b1;

  tdec_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_req_i.valid),
    .in_ready_o   (in_req_i.ready),
    .in_byte_i    (in_req_i.in_byte),
    .in_last_i    (in_req_i.is_last),
    .cfg_we_i     (cfg_i.valid),
    .cfg_mode_i   (cfg_i.decode_mode),
    .bund_valid_o (bund_valid),
    .bund_ready_i (bund_ready),
    .bund_o       (bund)
  );

  // result register, one byte per output request
  tdec_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bund_valid_i (bund_valid),
    .bund_ready_o (bund_ready),
    .bund_i       (bund),
    .out_valid_o  (out_res_o.valid),
    .out_ready_i  (out_res_o.ready),
    .out_byte_o   (out_res_o.out_byte),
    .has_byte_o   (out_res_o.has_byte),
    .last_out_o   (out_res_o.last_out)
  );

endmodule
